/* hw/rtl/lmps_pkg.sv */
// Package with the constants, types and codes shared by the lamp matrix scanner.
package lmps_pkg;

    localparam int LAMP_COUNT      = 16;
    localparam int ROWS_PER_COLUMN = 4;
    localparam int MAX_COLUMNS     = 4;
    localparam int OUT_ROWS        = 4;
    localparam int LAMP_IDX_W      = $clog2(LAMP_COUNT);
    localparam int SCAN_ROWS       = (ROWS_PER_COLUMN < OUT_ROWS) ? ROWS_PER_COLUMN : OUT_ROWS;
    localparam int SCAN_ADDR_W     = 7;
    localparam int DUR_SCALE       = 10;
    localparam int DUR_PROD_W      = 20;

    localparam logic [2:0] COLUMN_OFF = 3'b111;

    localparam logic [1:0] PHASE_FIRST  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    // Word address of the only configuration register.
    localparam logic REG_COLUMNS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_SET        = 2'd1,
        MODE_SCAN_RESET = 2'd2,
        MODE_SCAN_MATCH = 2'd3
    } lmps_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_SCAN,
        ST_RESULT
    } lmps_state_t;

    typedef struct packed {
        logic [2:0][7:0]  levels;
        logic [2:0][15:0] durations;
        logic [1:0]       phase_count;
        logic [1:0]       phase;
        logic [31:0]      phase_start;
    } lamp_entry_t;

    typedef struct packed {
        logic                  en;
        logic [LAMP_IDX_W-1:0] addr;
        lamp_entry_t           data;
    } lmps_wr_t;

    typedef struct packed {
        logic        update;
        logic [1:0]  phase;
        logic [31:0] phase_start;
    } lmps_adv_t;

endpackage

/* hw/rtl/lmps_in_if.sv */
// Request channel interface carrying one tick, set or scan request.
interface lmps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] tick_count;
    logic [7:0]  lamp_index;
    logic [7:0]  level_first;
    logic [7:0]  level_second;
    logic [7:0]  level_third;
    logic [15:0] time_first;
    logic [15:0] time_second;
    logic [15:0] time_third;
    logic [1:0]  phase_count;

    modport source (
        output valid, mode, tick_count, lamp_index, level_first, level_second,
               level_third, time_first, time_second, time_third, phase_count,
        input  ready
    );

    modport sink (
        input  valid, mode, tick_count, lamp_index, level_first, level_second,
               level_third, time_first, time_second, time_third, phase_count,
        output ready
    );
endinterface

/* hw/rtl/lmps_out_if.sv */
// Result channel interface carrying one column drive and its row levels.
interface lmps_out_if;
    logic              valid;
    logic              ready;
    logic signed [2:0] column_drive;
    logic [7:0]        row_level_a;
    logic [7:0]        row_level_b;
    logic [7:0]        row_level_c;
    logic [7:0]        row_level_d;

    modport source (
        output valid, column_drive, row_level_a, row_level_b, row_level_c, row_level_d,
        input  ready
    );

    modport sink (
        input  valid, column_drive, row_level_a, row_level_b, row_level_c, row_level_d,
        output ready
    );
endinterface

/* hw/rtl/lmps_lamp_store.sv */
// Register file holding the per-lamp levels, durations, phase and timer start.
module lmps_lamp_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lmps_pkg::lmps_wr_t             wr,
    input  logic [lmps_pkg::LAMP_IDX_W-1:0] raddr,
    output lmps_pkg::lamp_entry_t          rdata
);
    import lmps_pkg::*;

    lamp_entry_t entries_reg [LAMP_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAMP_COUNT; i++)
            begin
                entries_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            entries_reg[wr.addr] <= wr.data;
        end
    end

    assign rdata = entries_reg[raddr];

endmodule

/* hw/rtl/lmps_phase_unit.sv */
// Shared phase-advance unit: decides whether one lamp moves to its next phase.
module lmps_phase_unit (
    input  lmps_pkg::lamp_entry_t entry,
    input  logic [31:0]           now,
    output lmps_pkg::lmps_adv_t   adv
);
    import lmps_pkg::*;

    logic [31:0]           limit;
    logic [31:0]           elapsed;
    logic [1:0]            next_phase;
    logic [15:0]           duration;
    logic [DUR_PROD_W-1:0] scaled;

    always_comb
    begin
        elapsed    = now - entry.phase_start;
        duration   = '0;
        next_phase = PHASE_FIRST;
        case (entry.phase)
            PHASE_FIRST:
            begin
                duration   = entry.durations[0];
                next_phase = PHASE_SECOND;
            end
            PHASE_SECOND:
            begin
                duration   = entry.durations[1];
                next_phase = (entry.phase_count > 2'd2) ? PHASE_THIRD : PHASE_FIRST;
            end
            PHASE_THIRD:
            begin
                duration   = entry.durations[2];
                next_phase = PHASE_FIRST;
            end
            default:
            begin
                duration   = '0;
                next_phase = PHASE_FIRST;
            end
        endcase
        scaled = DUR_PROD_W'(duration) * DUR_PROD_W'(DUR_SCALE);
        // The unreachable fourth phase falls back to phase zero once elapsed time reaches now, if now is nonzero.
        limit = (entry.phase == 2'd3) ? now : 32'(scaled);

        if (entry.phase_count <= 2'd1)
        begin
            adv.update      = 1'b1;
            adv.phase       = PHASE_FIRST;
            adv.phase_start = now;
        end
        else
        begin
            adv.update      = (limit != '0) && (elapsed >= limit);
            adv.phase       = next_phase;
            adv.phase_start = now;
        end
    end

endmodule

/* hw/rtl/lmps_sequencer.sv */
// Sequencer that walks the lamp store for ticks and scans and holds the result register.
module lmps_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [2:0]                      columns_in_use,
    lmps_in_if.sink                         request,
    lmps_out_if.source                      result,
    output lmps_pkg::lmps_wr_t              wr,
    output logic [lmps_pkg::LAMP_IDX_W-1:0] raddr,
    input  lmps_pkg::lamp_entry_t           rdata
);
    import lmps_pkg::*;

    localparam logic [LAMP_IDX_W-1:0] LAMP_LAST = LAMP_IDX_W'(LAMP_COUNT - 1);
    localparam logic [1:0]            ROW_LAST  = 2'(SCAN_ROWS - 1);

    lmps_state_t                state_reg, state_next;
    logic [LAMP_IDX_W-1:0]      idx_reg, idx_next;
    logic [1:0]                 row_reg, row_next;
    logic [1:0]                 col_reg, col_next;
    logic [31:0]                tick_reg, tick_next;
    logic [OUT_ROWS-1:0][7:0]   acc_reg, acc_next;
    logic [2:0]                 acc_col_reg, acc_col_next;
    logic                       out_valid_reg, out_valid_next;
    logic [2:0]                 out_col_reg, out_col_next;
    logic [OUT_ROWS-1:0][7:0]   out_rows_reg, out_rows_next;

    lmps_adv_t                  adv;
    logic [SCAN_ADDR_W-1:0]     scan_addr;
    logic [7:0]                 level;
    logic [2:0]                 col_inc;

    lmps_phase_unit u_phase (
        .entry (rdata),
        .now   (tick_reg),
        .adv   (adv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        acc_col_reg  <= acc_col_next;
        out_col_reg  <= out_col_next;
        out_rows_reg <= out_rows_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        tick_next      = tick_reg;
        acc_next       = acc_reg;
        acc_col_next   = acc_col_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_col_next   = out_col_reg;
        out_rows_next  = out_rows_reg;
        wr             = '0;
        raddr          = idx_reg;
        scan_addr      = SCAN_ADDR_W'(col_reg) * SCAN_ADDR_W'(ROWS_PER_COLUMN)
                         + SCAN_ADDR_W'(row_reg);
        level          = '0;
        col_inc        = {1'b0, col_reg} + 3'd1;

        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    case (lmps_mode_t'(request.mode))
                        MODE_TICK:
                        begin
                            tick_next  = request.tick_count;
                            idx_next   = '0;
                            state_next = ST_TICK;
                        end
                        MODE_SET:
                        begin
                            if (32'(request.lamp_index) < 32'(LAMP_COUNT))
                            begin
                                wr.en                  = 1'b1;
                                wr.addr                = request.lamp_index[LAMP_IDX_W-1:0];
                                wr.data.levels         = {request.level_third,
                                                          request.level_second,
                                                          request.level_first};
                                wr.data.durations      = {request.time_third,
                                                          request.time_second,
                                                          request.time_first};
                                wr.data.phase_count    = request.phase_count;
                                wr.data.phase          = PHASE_FIRST;
                                wr.data.phase_start    = tick_reg;
                            end
                        end
                        MODE_SCAN_RESET:
                        begin
                            acc_col_next = COLUMN_OFF;
                            acc_next     = '0;
                            state_next   = ST_RESULT;
                        end
                        MODE_SCAN_MATCH:
                        begin
                            acc_col_next = {1'b0, col_reg};
                            acc_next     = '0;
                            row_next     = '0;
                            state_next   = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK:
            begin
                raddr                = idx_reg;
                wr.en                = adv.update;
                wr.addr              = idx_reg;
                wr.data              = rdata;
                wr.data.phase        = adv.phase;
                wr.data.phase_start  = adv.phase_start;
                if (idx_reg == LAMP_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                raddr = scan_addr[LAMP_IDX_W-1:0];
                if (scan_addr < SCAN_ADDR_W'(LAMP_COUNT))
                begin
                    case (rdata.phase)
                        PHASE_FIRST:  level = rdata.levels[0];
                        PHASE_SECOND: level = rdata.levels[1];
                        PHASE_THIRD:  level = rdata.levels[2];
                        default:      level = '0;
                    endcase
                end
                acc_next[row_reg] = level;
                if (row_reg == ROW_LAST)
                begin
                    col_next   = (col_inc >= columns_in_use) ? 2'd0 : col_inc[1:0];
                    state_next = ST_RESULT;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = acc_col_reg;
                    out_rows_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign request.ready       = (state_reg == ST_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.column_drive = out_col_reg;
    assign result.row_level_a  = out_rows_reg[0];
    assign result.row_level_b  = out_rows_reg[1];
    assign result.row_level_c  = out_rows_reg[2];
    assign result.row_level_d  = out_rows_reg[3];

    // The store is written only by a set request or during the tick sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_TICK)
               || (state_reg == ST_IDLE && request.valid && request.mode == MODE_SET))
        else $error("lamp store written outside a set or tick sweep");

    // The tick sweep visits the lamps in order, one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK && idx_reg != LAMP_LAST) |=> idx_reg == $past(idx_reg) + 1'b1)
        else $error("tick sweep skipped a lamp");

    // A new result appears only from the result hand-off state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result raised outside the hand-off state");

    // A scan match starts its row walk at row zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready && request.mode == MODE_SCAN_MATCH)
        |=> (state_reg == ST_SCAN && row_reg == 2'd0))
        else $error("scan walk did not start at row zero");

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> out_valid_reg && $stable(out_col_reg)
                                          && $stable(out_rows_reg))
        else $error("pending result was overwritten");

endmodule

/* hw/rtl/lamp_matrix_phase_scanner_unit.sv */
// Top level of the lamp matrix scanner with blink phases and its configuration port.
//
//  Channel   Direction  Handshake          Contents
//  request   in         valid/ready        mode, tick count, lamp load fields
//  result    out        valid/ready        column drive and four row levels
//  apb       in/out     psel/penable/pready columns_in_use at byte address 0
//
// A tick request is accepted and then the shared phase-advance unit sweeps the 16-entry
// lamp store lamp by lamp through its single read port. A set request writes the store
// as it is accepted. A scan match walks one row per cycle after acceptance, and a scan
// reset goes straight to the hand-off; both wait there until the result register is free.
// Reset clears the whole lamp store, the tick and column state and sets columns_in_use to 4.
// The block accepts a new request while the last result still waits to be taken; only a
// second result stalls in the hand-off state until the result register is free.
module lamp_matrix_phase_scanner_unit (
    input  logic        clk,
    input  logic        rst_n,
    lmps_in_if.sink     request,
    lmps_out_if.source  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lmps_pkg::*;

    logic [2:0]            columns_reg, columns_next;
    logic                  cfg_write;
    logic [2:0]            cfg_value;
    lmps_wr_t              wr;
    logic [LAMP_IDX_W-1:0] raddr;
    lamp_entry_t           rdata;

    // Registers are decoded on word addresses; the byte offset bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_COLUMNS_IN_USE) && (paddr[1:0] == paddr[1:0]);
    assign cfg_value = pwdata[2:0];

    always_comb
    begin
        columns_next = columns_reg;
        if (cfg_write)
        begin
            // Values beyond the matrix width saturate to the full four columns.
            columns_next = (cfg_value > 3'(MAX_COLUMNS)) ? 3'(MAX_COLUMNS) : cfg_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= 3'(MAX_COLUMNS);
        end
        else
        begin
            columns_reg <= columns_next;
        end
    end

    assign prdata = (paddr[2] == REG_COLUMNS_IN_USE) ? {29'd0, columns_reg} : 32'd0;

    lmps_lamp_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    lmps_sequencer u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .columns_in_use (columns_reg),
        .request        (request),
        .result         (result),
        .wr             (wr),
        .raddr          (raddr),
        .rdata          (rdata)
    );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the lamp matrix phase scanner top level.
module tb;
    import lmps_pkg::*;

    // Phase code that a lamp never reaches through normal loads and ticks.
    localparam logic [1:0] PHASE_UNUSED = 2'd3;
    // Byte address of the columns_in_use register on the configuration port.
    localparam logic [2:0] COLUMNS_ADDR = 3'(4 * REG_COLUMNS_IN_USE);
    // Cycles allowed for a tick sweep or a load to finish when no result marks its end.
    localparam int SETTLE_CYCLES = 40;

    // One request as it is driven on the request channel.
    typedef struct {
        lmps_mode_t  mode;
        logic [31:0] tick_count;
        logic [7:0]  lamp_index;
        logic [7:0]  level_first;
        logic [7:0]  level_second;
        logic [7:0]  level_third;
        logic [15:0] time_first;
        logic [15:0] time_second;
        logic [15:0] time_third;
        logic [1:0]  phase_count;
    } lamp_req_t;

    // One expected scan result: the column drive and the four row levels.
    typedef struct packed {
        logic [2:0]      column;
        logic [3:0][7:0] rows;
    } scan_out_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    lmps_in_if  req_ch();
    lmps_out_if res_ch();

    lamp_matrix_phase_scanner_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Our own copy of the lamp store, the tick and column state and the register.
    logic [7:0]  lamp_lvl   [LAMP_COUNT][3];
    logic [15:0] lamp_dur   [LAMP_COUNT][3];
    logic [1:0]  lamp_cnt   [LAMP_COUNT];
    logic [1:0]  lamp_ph    [LAMP_COUNT];
    logic [31:0] lamp_start [LAMP_COUNT];
    logic [31:0] last_tick;
    logic [1:0]  scan_col;
    logic [2:0]  cols_used;

    // Scan results predicted but not yet seen on the result channel.
    scan_out_t pending_scans [$];

    int errors;
    int n_ticks;
    int n_loads;
    int n_scans_checked;
    int n_settings;
    // While set, neither side inserts idle cycles.
    bit steady;
    // Running millisecond count used to build well-formed tick sequences.
    logic [31:0] tick_now;

    // The clock runs with a period of 12 time units.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run, far above the slowest correct run.
    initial
    begin
        #(12 * 600000);
        $display("lamp_matrix_phase_scanner_unit verification failed");
        $finish;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Puts the predicted state into its reset condition.
    function automatic void clear_lamp_model();
        int n;
        for (n = 0; n < LAMP_COUNT; n++)
        begin
            lamp_lvl[n]   = '{8'd0, 8'd0, 8'd0};
            lamp_dur[n]   = '{16'd0, 16'd0, 16'd0};
            lamp_cnt[n]   = 2'd0;
            lamp_ph[n]    = PHASE_FIRST;
            lamp_start[n] = 32'd0;
        end
        last_tick = 32'd0;
        scan_col  = 2'd0;
        cols_used = 3'(MAX_COLUMNS);
    endfunction

    // A tick moves every lamp whose phase has run out to its next phase. Lamps with a
    // phase count of zero or one stay in the first phase but restart their timer.
    function automatic void advance_lamps(input logic [31:0] now);
        int n;
        logic [31:0] limit;
        logic [1:0] nxt;
        last_tick = now;
        for (n = 0; n < LAMP_COUNT; n++)
        begin
            if (lamp_cnt[n] <= 2'd1)
            begin
                lamp_ph[n]    = PHASE_FIRST;
                lamp_start[n] = now;
            end
            else
            begin
                if (lamp_ph[n] == PHASE_UNUSED)
                begin
                    // An unused phase falls back once elapsed time reaches now, if now is nonzero.
                    limit = now;
                    nxt   = PHASE_FIRST;
                end
                else
                begin
                    limit = 32'(lamp_dur[n][lamp_ph[n]]) * 32'(DUR_SCALE);
                    if (lamp_ph[n] == PHASE_FIRST)
                        nxt = PHASE_SECOND;
                    else if (lamp_ph[n] == PHASE_SECOND)
                        nxt = (lamp_cnt[n] > 2'd2) ? PHASE_THIRD : PHASE_FIRST;
                    else
                        nxt = PHASE_FIRST;
                end
                // The elapsed time wraps modulo 2^32; a zero limit holds the phase.
                if (limit != 32'd0 && (now - lamp_start[n]) >= limit)
                begin
                    lamp_ph[n]    = nxt;
                    lamp_start[n] = now;
                end
            end
        end
    endfunction

    // Applies one accepted request to the predicted state and queues any scan result.
    function automatic void apply_lamp_request(input lamp_req_t r);
        scan_out_t e;
        int row;
        int idx;
        int nx;
        case (r.mode)
            MODE_TICK:
            begin
                advance_lamps(r.tick_count);
                n_ticks++;
            end
            MODE_SET:
            begin
                if (r.lamp_index < LAMP_COUNT)
                begin
                    lamp_lvl[r.lamp_index] = '{r.level_first, r.level_second, r.level_third};
                    lamp_dur[r.lamp_index] = '{r.time_first, r.time_second, r.time_third};
                    lamp_cnt[r.lamp_index]   = r.phase_count;
                    lamp_ph[r.lamp_index]    = PHASE_FIRST;
                    lamp_start[r.lamp_index] = last_tick;
                end
                n_loads++;
            end
            MODE_SCAN_RESET:
            begin
                e.column = COLUMN_OFF;
                e.rows   = '0;
                pending_scans.push_back(e);
            end
            default:
            begin
                e.column = {1'b0, scan_col};
                e.rows   = '0;
                for (row = 0; row < OUT_ROWS; row++)
                begin
                    idx = int'(scan_col) * ROWS_PER_COLUMN + row;
                    if (row < ROWS_PER_COLUMN && idx < LAMP_COUNT
                        && lamp_ph[idx] != PHASE_UNUSED)
                        e.rows[row] = lamp_lvl[idx][lamp_ph[idx]];
                end
                pending_scans.push_back(e);
                // A register value of zero sends the column back to zero every time.
                nx = int'(scan_col) + 1;
                if (nx >= int'(cols_used))
                    nx = 0;
                scan_col = 2'(nx);
            end
        endcase
    endfunction

    // Both channels are watched here: accepted requests update the prediction, and
    // accepted results are checked against the oldest prediction, field by field.
    always @(posedge clk)
    begin : watch_channels
        lamp_req_t seen;
        scan_out_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen.mode         = lmps_mode_t'(req_ch.mode);
                seen.tick_count   = req_ch.tick_count;
                seen.lamp_index   = req_ch.lamp_index;
                seen.level_first  = req_ch.level_first;
                seen.level_second = req_ch.level_second;
                seen.level_third  = req_ch.level_third;
                seen.time_first   = req_ch.time_first;
                seen.time_second  = req_ch.time_second;
                seen.time_third   = req_ch.time_third;
                seen.phase_count  = req_ch.phase_count;
                apply_lamp_request(seen);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_scans.size() == 0)
                    report_mismatch("result with nothing expected", 32'(res_ch.column_drive),
                                    32'd0);
                else
                begin
                    want = pending_scans.pop_front();
                    n_scans_checked++;
                    if (res_ch.column_drive !== want.column)
                        report_mismatch("column_drive", 32'(res_ch.column_drive), 32'(want.column));
                    if (res_ch.row_level_a !== want.rows[0])
                        report_mismatch("row_level_a", 32'(res_ch.row_level_a), 32'(want.rows[0]));
                    if (res_ch.row_level_b !== want.rows[1])
                        report_mismatch("row_level_b", 32'(res_ch.row_level_b), 32'(want.rows[1]));
                    if (res_ch.row_level_c !== want.rows[2])
                        report_mismatch("row_level_c", 32'(res_ch.row_level_c), 32'(want.rows[2]));
                    if (res_ch.row_level_d !== want.rows[3])
                        report_mismatch("row_level_d", 32'(res_ch.row_level_d), 32'(want.rows[3]));
                end
            end
        end
    end

    // The result side stalls at random, about nine times in a hundred, unless the run is steady.
    always @(posedge clk)
    begin
        res_ch.ready <= steady || ($urandom_range(99) >= 9);
    end

    // Sends one request. The valid line is left high after acceptance so that a request
    // that follows right away does not lower and raise it in the same step; the caller
    // lowers it through settle_block or the next idle gap.
    task automatic send_request(input lamp_req_t r);
        while (!steady && $urandom_range(99) < 9)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= r.mode;
        req_ch.tick_count   <= r.tick_count;
        req_ch.lamp_index   <= r.lamp_index;
        req_ch.level_first  <= r.level_first;
        req_ch.level_second <= r.level_second;
        req_ch.level_third  <= r.level_third;
        req_ch.time_first   <= r.time_first;
        req_ch.time_second  <= r.time_second;
        req_ch.time_third   <= r.time_third;
        req_ch.phase_count  <= r.phase_count;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Drops valid, waits for every expected result, then lets a tick sweep run out.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes columns_in_use through the setup and access cycles of the port.
    task automatic write_columns(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= COLUMNS_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // Values above four saturate to four.
        cols_used = (value[2:0] > 3'(MAX_COLUMNS)) ? 3'(MAX_COLUMNS) : value[2:0];
        n_settings++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // A request with every field random; callers then fix the fields that matter.
    function automatic lamp_req_t noise_request(input lmps_mode_t m);
        lamp_req_t r;
        r.mode         = m;
        r.tick_count   = $urandom;
        r.lamp_index   = 8'($urandom);
        r.level_first  = 8'($urandom);
        r.level_second = 8'($urandom);
        r.level_third  = 8'($urandom);
        r.time_first   = 16'($urandom);
        r.time_second  = 16'($urandom);
        r.time_third   = 16'($urandom);
        r.phase_count  = 2'($urandom);
        return r;
    endfunction

    function automatic lamp_req_t tick_request(input logic [31:0] t);
        lamp_req_t r;
        r = noise_request(MODE_TICK);
        r.tick_count = t;
        return r;
    endfunction

    function automatic lamp_req_t load_request(input logic [7:0] idx, input logic [23:0] lv,
                                               input logic [47:0] tm, input logic [1:0] cnt);
        lamp_req_t r;
        r = noise_request(MODE_SET);
        r.lamp_index   = idx;
        r.level_first  = lv[23:16];
        r.level_second = lv[15:8];
        r.level_third  = lv[7:0];
        r.time_first   = tm[47:32];
        r.time_second  = tm[31:16];
        r.time_third   = tm[15:0];
        r.phase_count  = cnt;
        return r;
    endfunction

    // Mostly short durations so that phases run out under small tick steps.
    function automatic logic [15:0] pick_duration();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 16'($urandom_range(6, 1));
        else if (roll < 75)
            return 16'd0;
        else if (roll < 90)
            return 16'($urandom_range(100));
        return 16'($urandom);
    endfunction

    // Builds one random request. Ticks mostly move forward in small steps, with some
    // long jumps, arbitrary counts and steps across the 2^32 wrap.
    function automatic lamp_req_t random_request();
        lamp_req_t r;
        int roll;
        int step;
        roll = $urandom_range(99);
        if (roll < 35)
        begin
            step = $urandom_range(99);
            if (step < 70)
                tick_now = tick_now + 32'($urandom_range(40));
            else if (step < 85)
                tick_now = tick_now + 32'($urandom_range(700));
            else if (step < 95)
                tick_now = $urandom;
            else
                tick_now = 32'hFFFF_FFF0 + 32'($urandom_range(15));
            r = tick_request(tick_now);
        end
        else if (roll < 60)
        begin
            r = noise_request(MODE_SET);
            if ($urandom_range(99) < 85)
                r.lamp_index = 8'($urandom_range(LAMP_COUNT - 1));
            r.time_first  = pick_duration();
            r.time_second = pick_duration();
            r.time_third  = pick_duration();
        end
        else if (roll < 90)
            r = noise_request(MODE_SCAN_MATCH);
        else
            r = noise_request(MODE_SCAN_RESET);
        return r;
    endfunction

    // Extremes of the fields, each request kind, out-of-range loads, phase cycling
    // through all three phases and the tick count wrapping past 2^32.
    task automatic test_directed_cases();
        send_request(noise_request(MODE_SCAN_MATCH));
        send_request(noise_request(MODE_SCAN_RESET));
        send_request(load_request(8'd0, 24'hFF55AA, {16'd1, 16'd2, 16'hFFFF}, 2'd3));
        // Zero durations hold a two-phase lamp in its first phase forever.
        send_request(load_request(8'd15, 24'h123456, {16'd0, 16'd0, 16'd0}, 2'd2));
        // Indexes past the lamp array are ignored.
        send_request(load_request(8'd16, 24'hEEEEEE, {16'd1, 16'd1, 16'd1}, 2'd3));
        send_request(load_request(8'hFF, 24'hDDDDDD, {16'd1, 16'd1, 16'd1}, 2'd3));
        // Phase counts of one and zero keep the lamp in phase zero.
        send_request(load_request(8'd5, 24'h0102FF, {16'd1, 16'd1, 16'd1}, 2'd1));
        send_request(load_request(8'd6, 24'h00FF00, {16'd1, 16'd1, 16'd1}, 2'd0));
        send_request(tick_request(32'd10));
        repeat (5) send_request(noise_request(MODE_SCAN_MATCH));
        send_request(tick_request(32'd30));
        // A huge jump, then small steps across the wrap of the millisecond count.
        send_request(tick_request(32'hFFFF_FFFF));
        send_request(tick_request(32'd4));
        send_request(tick_request(32'd9));
        send_request(noise_request(MODE_SCAN_MATCH));
        send_request(load_request(8'd0, 24'h000000, {16'd0, 16'd0, 16'd0}, 2'd3));
        send_request(noise_request(MODE_SCAN_RESET));
        send_request(load_request(8'd3, 24'hFFFFFF, {16'hFFFF, 16'hFFFF, 16'hFFFF}, 2'd3));
        send_request(tick_request(32'h8000_0000));
        send_request(noise_request(MODE_SCAN_MATCH));
        settle_block();
    endtask

    // Column wrap under every register setting, with values above four saturating and
    // the upper data bits ignored.
    task automatic test_column_wrap();
        logic [31:0] settings [8];
        int s;
        settings = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd7, 32'd5, 32'hFFFF_FFFB, 32'hFFFF_FFF8};
        for (s = 0; s < 8; s++)
        begin
            write_columns(settings[s]);
            repeat (5) send_request(noise_request(MODE_SCAN_MATCH));
            settle_block();
        end
        write_columns(32'd4);
    endtask

    // Random traffic in chunks, each under its own register setting; one chunk runs
    // with no idle cycles on either side.
    task automatic test_random_blink();
        int chunk;
        int k;
        tick_now = $urandom;
        for (chunk = 0; chunk < 8; chunk++)
        begin
            steady = (chunk == 3);
            for (k = 0; k < 60; k++)
                send_request(random_request());
            settle_block();
            write_columns(32'($urandom_range(MAX_COLUMNS)));
        end
        steady = 1'b0;
        // End on the widest setting, then one last short burst.
        write_columns(32'd4);
        for (k = 0; k < 10; k++)
            send_request(random_request());
        settle_block();
    endtask

    initial
    begin
        errors          = 0;
        n_ticks         = 0;
        n_loads         = 0;
        n_scans_checked = 0;
        n_settings      = 0;
        steady          = 1'b0;
        tick_now        = 32'd0;
        clear_lamp_model();
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= 3'd0;
        pwdata              <= 32'd0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_TICK;
        req_ch.tick_count   <= 32'd0;
        req_ch.lamp_index   <= 8'd0;
        req_ch.level_first  <= 8'd0;
        req_ch.level_second <= 8'd0;
        req_ch.level_third  <= 8'd0;
        req_ch.time_first   <= 16'd0;
        req_ch.time_second  <= 16'd0;
        req_ch.time_third   <= 16'd0;
        req_ch.phase_count  <= 2'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_column_wrap();
        test_random_blink();

        // settle_block has already waited for every expected result and the latency.
        if (pending_scans.size() != 0)
            report_mismatch("results never delivered", 32'(pending_scans.size()), 32'd0);
        $display("Covered %0d ticks, %0d lamp loads and %0d checked scan results,",
                 n_ticks, n_loads, n_scans_checked);
        $display("under %0d column settings including zero and saturated values.",
                 n_settings);
        if (errors == 0)
            $display("lamp_matrix_phase_scanner_unit verification clean");
        else
            $display("lamp_matrix_phase_scanner_unit verification failed");
        $finish;
    end

endmodule
